[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define SVM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SVM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/svm_pkg.sv]
// ----------------------------------------------------------------------------
// svm_pkg
// Shared types and constants of the sample voice mixer.
// ----------------------------------------------------------------------------
package svm_pkg;

    localparam int VOICES       = 24;
    localparam int CLIPS        = 32;
    localparam int SAMPLE_DEPTH = 524288;

    localparam int VOICE_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int VCNT_W  = $clog2(VOICES + 1);
    localparam int CLIP_W  = 5;
    localparam int CIDX_W  = (CLIPS > 1) ? $clog2(CLIPS) : 1;
    localparam int ADDR_W  = 19;
    localparam int SADDR_W = $clog2(SAMPLE_DEPTH);
    localparam int SMP_W   = 16;
    localparam int LEN_W   = 16;
    localparam int VOL_W   = 10;
    localparam int PITCH_W = 12;
    localparam int GAIN_W  = 9;
    localparam int STEP_W  = 11;
    localparam int POS_W   = 24;

    localparam logic [GAIN_W-1:0] GAIN_MAX = 9'd384;
    localparam logic [STEP_W-1:0] STEP_MIN = 11'd64;
    localparam logic [STEP_W-1:0] STEP_MAX = 11'd1024;
    localparam logic [POS_W-1:0]  POS_MAX  = 24'hFFFFFF;
    localparam logic signed [17:0] OUT_LIMIT = 18'sd32767;

    localparam int VREC_W = CIDX_W + POS_W + GAIN_W + STEP_W;
    localparam int CREC_W = ADDR_W + LEN_W;

    typedef enum logic [2:0]
    {
        KIND_LOAD_SAMPLE = 3'd0,
        KIND_LOAD_CLIP   = 3'd1,
        KIND_PLAY        = 3'd2,
        KIND_STOP        = 3'd3,
        KIND_TICK        = 3'd4
    } kind_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_PLAY_CLIP,
        ST_SCAN,
        ST_MIX_VREAD,
        ST_MIX_CREAD,
        ST_MIX_SREAD,
        ST_MIX_ACC,
        ST_DONE
    } state_t;

    typedef struct packed
    {
        logic [CIDX_W-1:0] clip;
        logic [POS_W-1:0]  pos;
        logic [GAIN_W-1:0] gain;
        logic [STEP_W-1:0] step;
    } voice_t;

endpackage

[hw/rtl/svm_ram.sv]
// ----------------------------------------------------------------------------
// svm_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module svm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[hw/rtl/sample_voice_mixer_core.sv]
// ----------------------------------------------------------------------------
// sample_voice_mixer_core
// Polyphonic sample playback mixer with voice stealing.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one command per transfer: sample
// load, clip entry load, play, stop all or tick. Output channel
// (out_valid/out_ready) carries one mixed frame per tick.
// Sample loads, clip loads and stop all are done in the idle state. A play
// reads the clip table, ends there for an invalid or empty clip, else scans
// the voice memory one entry per cycle for an idle or the quietest voice.
// A tick visits the voices in order; an idle voice is skipped, and each
// active voice reads the voice memory, the clip memory and the sample
// memory in turn, then writes the voice back.
// Reset clears the voice active bits and the clip valid bits (unwritten clip
// lengths read as zero); memories themselves are not cleared.
// A finished frame sits in the output register; a stalled receiver holds
// the block at the next item until the frame is taken.
// ----------------------------------------------------------------------------
module sample_voice_mixer_core
    import svm_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         kind,
    input  logic [svm_pkg::ADDR_W-1:0]         address,
    input  logic signed [svm_pkg::SMP_W-1:0]   sample,
    input  logic [svm_pkg::CLIP_W-1:0]         clip,
    input  logic [svm_pkg::ADDR_W-1:0]         clip_start,
    input  logic [svm_pkg::LEN_W-1:0]          clip_length,
    input  logic [svm_pkg::VOL_W-1:0]          volume,
    input  logic [svm_pkg::PITCH_W-1:0]        pitch,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [svm_pkg::SMP_W-1:0]   mixed_sample
);

`include "assert_macros.svh"

    state_t state_reg, state_next;

    logic [VOICES-1:0] active_reg, active_next;
    logic [CLIPS-1:0]  cvalid_reg, cvalid_next;
    logic [VOICE_W-1:0] vidx_reg, vidx_next;
    logic [VOICE_W-1:0] slot_reg, slot_next;
    logic [GAIN_W:0]    quiet_reg, quiet_next;
    logic               found_reg, found_next;
    logic [CIDX_W-1:0]  pclip_reg, pclip_next;
    logic [GAIN_W-1:0]  pgain_reg, pgain_next;
    logic [STEP_W-1:0]  pstep_reg, pstep_next;
    voice_t             vcur_reg, vcur_next;
    logic signed [17:0] sum_reg, sum_next;
    logic               ovalid_reg, ovalid_next;
    logic signed [SMP_W-1:0] out_reg, out_next;

    logic               v_we, c_we, s_we;
    logic [VOICE_W-1:0] v_addr;
    logic [CIDX_W-1:0]  c_addr;
    logic [SADDR_W-1:0] s_addr;
    voice_t             v_wdata, v_rdata;
    logic [CREC_W-1:0]  c_wdata, c_rdata;
    logic [SMP_W-1:0]   s_rdata;

    logic               accept;
    logic [ADDR_W-1:0]  c_start;
    logic [LEN_W-1:0]   c_len;
    logic [LEN_W-1:0]   cur_idx;
    logic [ADDR_W:0]    addr_sum;
    logic signed [SMP_W+GAIN_W:0] prod;
    logic signed [SMP_W+GAIN_W:0] scaled;
    logic signed [17:0] acc;
    logic [POS_W:0]     pos_sum;
    logic               last_voice;
    logic               clip_ok;

    svm_ram #(.WIDTH(VREC_W), .DEPTH(VOICES)) u_voice_ram (
        .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata)
    );

    svm_ram #(.WIDTH(CREC_W), .DEPTH(CLIPS)) u_clip_ram (
        .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata)
    );

    svm_ram #(.WIDTH(SMP_W), .DEPTH(SAMPLE_DEPTH)) u_sample_ram (
        .clk(clk), .we(s_we), .addr(s_addr), .wdata(sample), .rdata(s_rdata)
    );

    assign in_ready     = (state_reg == ST_IDLE) && !ovalid_reg;
    assign accept       = in_valid && in_ready;
    assign out_valid    = ovalid_reg;
    assign mixed_sample = out_reg;

    assign c_start    = c_rdata[CREC_W-1:LEN_W];
    assign c_len      = cvalid_reg[vcur_reg.clip] ? c_rdata[LEN_W-1:0] : '0;
    assign cur_idx    = vcur_reg.pos[POS_W-1:8];
    assign addr_sum   = {1'b0, c_start} + {{(ADDR_W-LEN_W+1){1'b0}}, cur_idx};
    assign prod       = $signed(s_rdata) * $signed({1'b0, vcur_reg.gain});
    assign scaled     = (prod < 0) ? -((-prod) >>> 8) : (prod >>> 8);
    assign acc        = sum_reg + scaled[17:0];
    assign pos_sum    = {1'b0, vcur_reg.pos} + {{(POS_W-STEP_W+1){1'b0}}, vcur_reg.step};
    assign last_voice = (vidx_reg == VOICE_W'(VOICES - 1));
    assign clip_ok    = (int'(clip) < CLIPS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            active_reg <= '0;
            cvalid_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            cvalid_reg <= cvalid_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vidx_reg  <= vidx_next;
        slot_reg  <= slot_next;
        quiet_reg <= quiet_next;
        found_reg <= found_next;
        pclip_reg <= pclip_next;
        pgain_reg <= pgain_next;
        pstep_reg <= pstep_next;
        vcur_reg  <= vcur_next;
        sum_reg   <= sum_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        cvalid_next = cvalid_reg;
        ovalid_next = ovalid_reg;
        vidx_next   = vidx_reg;
        slot_next   = slot_reg;
        quiet_next  = quiet_reg;
        found_next  = found_reg;
        pclip_next  = pclip_reg;
        pgain_next  = pgain_reg;
        pstep_next  = pstep_reg;
        vcur_next   = vcur_reg;
        sum_next    = sum_reg;
        out_next    = out_reg;
        v_we        = 1'b0;
        c_we        = 1'b0;
        s_we        = 1'b0;
        v_addr      = vidx_reg;
        c_addr      = clip[CIDX_W-1:0];
        s_addr      = address[SADDR_W-1:0];
        v_wdata     = vcur_reg;
        c_wdata     = {clip_start, clip_length};

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        KIND_LOAD_SAMPLE:
                        begin
                            s_we = (int'(address) < SAMPLE_DEPTH);
                        end
                        KIND_LOAD_CLIP:
                        begin
                            if (clip_ok)
                            begin
                                c_we = 1'b1;
                                cvalid_next[clip[CIDX_W-1:0]] = 1'b1;
                            end
                        end
                        KIND_PLAY:
                        begin
                            if (clip_ok && volume != '0)
                            begin
                                pclip_next = clip[CIDX_W-1:0];
                                pgain_next = (volume > VOL_W'(GAIN_MAX)) ? GAIN_MAX
                                                                         : volume[GAIN_W-1:0];
                                pstep_next = (pitch < PITCH_W'(STEP_MIN)) ? STEP_MIN :
                                             (pitch > PITCH_W'(STEP_MAX)) ? STEP_MAX :
                                             pitch[STEP_W-1:0];
                                state_next = ST_PLAY_CLIP;
                            end
                        end
                        KIND_STOP:
                        begin
                            active_next = '0;
                        end
                        KIND_TICK:
                        begin
                            sum_next   = '0;
                            vidx_next  = '0;
                            state_next = ST_MIX_VREAD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PLAY_CLIP:
            begin
                c_addr     = pclip_reg;
                vidx_next  = '0;
                v_addr     = '0;
                slot_next  = '0;
                quiet_next = '1;
                found_next = 1'b0;
                if (!cvalid_reg[pclip_reg] || c_rdata[LEN_W-1:0] == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!found_reg)
                begin
                    if (!active_reg[vidx_reg])
                    begin
                        slot_next  = vidx_reg;
                        found_next = 1'b1;
                    end
                    else if ({1'b0, v_rdata.gain} < quiet_reg)
                    begin
                        slot_next  = vidx_reg;
                        quiet_next = {1'b0, v_rdata.gain};
                    end
                end
                vidx_next = vidx_reg + 1'b1;
                v_addr    = vidx_reg + 1'b1;
                if (last_voice)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                v_we     = 1'b1;
                v_addr   = slot_reg;
                v_wdata  = '{clip: pclip_reg, pos: '0, gain: pgain_reg, step: pstep_reg};
                active_next[slot_reg] = 1'b1;
                state_next = ST_IDLE;
            end
            ST_MIX_VREAD:
            begin
                if (active_reg[vidx_reg])
                begin
                    state_next = ST_MIX_CREAD;
                end
                else if (last_voice)
                begin
                    out_next    = sum_reg[SMP_W-1:0];
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    vidx_next = vidx_reg + 1'b1;
                end
            end
            ST_MIX_CREAD:
            begin
                vcur_next  = v_rdata;
                c_addr     = v_rdata.clip;
                state_next = ST_MIX_SREAD;
            end
            ST_MIX_SREAD:
            begin
                c_addr = vcur_reg.clip;
                s_addr = addr_sum[SADDR_W-1:0];
                if (cur_idx >= c_len)
                begin
                    active_next[vidx_reg] = 1'b0;
                    state_next = ST_MIX_ACC;
                    vcur_next.step = '0;
                    vcur_next.gain = '0;
                end
                else
                begin
                    state_next = ST_MIX_ACC;
                end
            end
            ST_MIX_ACC:
            begin
                s_addr = addr_sum[SADDR_W-1:0];
                if (active_reg[vidx_reg])
                begin
                    sum_next = (acc > OUT_LIMIT) ? OUT_LIMIT :
                               (acc < -OUT_LIMIT) ? -OUT_LIMIT : acc;
                    v_we     = 1'b1;
                    v_wdata  = vcur_reg;
                    v_wdata.pos = pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];
                end
                if (last_voice)
                begin
                    out_next    = sum_next[SMP_W-1:0];
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    vidx_next  = vidx_reg + 1'b1;
                    state_next = ST_MIX_VREAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `SVM_ASSERT_IMP(a_out_busy, clk, rst_n, out_valid, !in_ready)
    `SVM_ASSERT_NXT(a_tick_starts, clk, rst_n, accept && kind == KIND_TICK,
                    state_reg == ST_MIX_VREAD)
    `SVM_ASSERT_IMP(a_sum_range, clk, rst_n, state_reg == ST_MIX_ACC,
                    sum_reg <= OUT_LIMIT && sum_reg >= -OUT_LIMIT)

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sample_voice_mixer_core. A generator builds the
// command stream: directed cases first, then random loads, plays, stops,
// unused kinds and ticks. A mirror of the mixer computes each frame when the
// command is queued. The stream never reads a sample that was not written
// before. A clocked driver and a clocked monitor move the transfers with
// random gaps on both channels and one long output stall. The monitor
// compares each frame with the oldest predicted frame.
// ----------------------------------------------------------------------------
module tb_top;
    import svm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0]         kind;
        logic [ADDR_W-1:0]  address;
        logic [SMP_W-1:0]   sample;
        logic [CLIP_W-1:0]  clip;
        logic [ADDR_W-1:0]  clip_start;
        logic [LEN_W-1:0]   clip_length;
        logic [VOL_W-1:0]   volume;
        logic [PITCH_W-1:0] pitch;
    } command_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] kind = '0;
    logic [ADDR_W-1:0] address = '0;
    logic signed [SMP_W-1:0] sample = '0;
    logic [CLIP_W-1:0] clip = '0;
    logic [ADDR_W-1:0] clip_start = '0;
    logic [LEN_W-1:0] clip_length = '0;
    logic [VOL_W-1:0] volume = '0;
    logic [PITCH_W-1:0] pitch = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [SMP_W-1:0] mixed_sample;

    command_t pending_cmds[$];
    logic signed [SMP_W-1:0] expected_frames[$];
    int accepted_cmds = 0;
    int taken_frames = 0;
    int hold_cycles = 0;
    bit hold_done = 1'b0;
    int fail_count = 0;

    // mixer mirror
    logic [SMP_W-1:0]   mem_samples[int];
    logic [ADDR_W-1:0]  tbl_start[CLIPS];
    logic [LEN_W-1:0]   tbl_length[CLIPS];
    bit                 v_active[VOICES];
    logic [CIDX_W-1:0]  v_clip[VOICES];
    logic [POS_W-1:0]   v_pos[VOICES];
    logic [GAIN_W-1:0]  v_gain[VOICES];
    logic [STEP_W-1:0]  v_step[VOICES];

    sample_voice_mixer_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .address(address), .sample(sample), .clip(clip),
        .clip_start(clip_start), .clip_length(clip_length),
        .volume(volume), .pitch(pitch),
        .out_valid(out_valid), .out_ready(out_ready),
        .mixed_sample(mixed_sample)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int sample_addr(int v);
        int c;
        c = v_clip[v];
        return (int'(tbl_start[c]) + int'(v_pos[v] >> 8)) % SAMPLE_DEPTH;
    endfunction

    function automatic logic signed [SMP_W-1:0] mix_one_frame();
        int sum;
        int scaled;
        int c;
        logic [POS_W:0] next_pos;
        sum = 0;
        for (int v = 0; v < VOICES; v++)
        begin
            if (!v_active[v])
                continue;
            c = v_clip[v];
            if ((v_pos[v] >> 8) >= tbl_length[c])
            begin
                v_active[v] = 1'b0;
                continue;
            end
            scaled = (int'($signed(mem_samples[sample_addr(v)])) * int'(v_gain[v])) / 256;
            sum += scaled;
            if (sum > 32767)
                sum = 32767;
            if (sum < -32767)
                sum = -32767;
            next_pos = {1'b0, v_pos[v]} + v_step[v];
            v_pos[v] = next_pos[POS_W] ? POS_MAX : next_pos[POS_W-1:0];
        end
        return sum[SMP_W-1:0];
    endfunction

    function automatic void start_voice(command_t cmd);
        int slot;
        int quietest;
        slot = 0;
        quietest = 1 << 30;
        if (cmd.volume == 0 || tbl_length[cmd.clip] == 0)
            return;
        for (int v = 0; v < VOICES; v++)
        begin
            if (!v_active[v])
            begin
                slot = v;
                break;
            end
            if (v_gain[v] < quietest)
            begin
                quietest = v_gain[v];
                slot = v;
            end
        end
        v_clip[slot] = cmd.clip;
        v_pos[slot] = '0;
        v_gain[slot] = (cmd.volume > GAIN_MAX) ? GAIN_MAX : cmd.volume[GAIN_W-1:0];
        v_step[slot] = (cmd.pitch < STEP_MIN) ? STEP_MIN :
                       (cmd.pitch > STEP_MAX) ? STEP_MAX : cmd.pitch[STEP_W-1:0];
        v_active[slot] = 1'b1;
    endfunction

    task automatic queue_cmd(command_t cmd);
        case (cmd.kind)
            KIND_LOAD_SAMPLE: mem_samples[int'(cmd.address)] = cmd.sample;
            KIND_LOAD_CLIP:
            begin
                tbl_start[cmd.clip] = cmd.clip_start;
                tbl_length[cmd.clip] = cmd.clip_length;
            end
            KIND_PLAY: start_voice(cmd);
            KIND_STOP:
                for (int v = 0; v < VOICES; v++)
                    v_active[v] = 1'b0;
            KIND_TICK: expected_frames.push_back(mix_one_frame());
            default: ;
        endcase
        pending_cmds.push_back(cmd);
    endtask

    function automatic command_t rand_cmd(logic [2:0] k);
        command_t cmd;
        cmd.kind = k;
        cmd.address = ADDR_W'($urandom());
        cmd.sample = SMP_W'($urandom());
        cmd.clip = CLIP_W'($urandom());
        cmd.clip_start = ADDR_W'($urandom());
        cmd.clip_length = LEN_W'($urandom());
        cmd.volume = VOL_W'($urandom());
        cmd.pitch = PITCH_W'($urandom());
        return cmd;
    endfunction

    // write every sample the next frame will read that is still unknown
    task automatic send_tick();
        command_t cmd;
        for (int v = 0; v < VOICES; v++)
        begin
            if (v_active[v] && (v_pos[v] >> 8) < tbl_length[v_clip[v]]
                && !mem_samples.exists(sample_addr(v)))
            begin
                cmd = rand_cmd(KIND_LOAD_SAMPLE);
                cmd.address = ADDR_W'(sample_addr(v));
                if ($urandom_range(0, 3) == 0)
                    cmd.sample = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                queue_cmd(cmd);
            end
        end
        queue_cmd(rand_cmd(KIND_TICK));
    endtask

    task automatic send_clip(int c, int start_addr, int len);
        command_t cmd;
        cmd = rand_cmd(KIND_LOAD_CLIP);
        cmd.clip = CLIP_W'(c);
        cmd.clip_start = ADDR_W'(start_addr);
        cmd.clip_length = LEN_W'(len);
        queue_cmd(cmd);
    endtask

    task automatic send_play(int c, int vol, int stp);
        command_t cmd;
        cmd = rand_cmd(KIND_PLAY);
        cmd.clip = CLIP_W'(c);
        cmd.volume = VOL_W'(vol);
        cmd.pitch = PITCH_W'(stp);
        queue_cmd(cmd);
    endtask

    initial
    begin
        command_t cmd;
        int pick;
        for (int c = 0; c < CLIPS; c++)
            tbl_length[c] = '0;
        for (int v = 0; v < VOICES; v++)
            v_active[v] = 1'b0;

        // directed
        cmd = rand_cmd(KIND_LOAD_SAMPLE);
        cmd.address = 19'h7FFFF;
        cmd.sample = 16'h8000;
        queue_cmd(cmd);
        cmd.address = '0;
        cmd.sample = 16'h7FFF;
        queue_cmd(cmd);
        send_clip(0, 524285, 6);
        send_clip(31, 0, 65535);
        send_play(5, 300, 256);
        send_play(0, 0, 256);
        send_play(0, 1023, 4095);
        send_play(31, 384, 0);
        send_play(0, 1, 64);
        send_tick();
        send_tick();
        send_clip(0, 524285, 1);
        send_tick();
        queue_cmd(rand_cmd(3'd5));
        queue_cmd(rand_cmd(3'd6));
        queue_cmd(rand_cmd(3'd7));
        send_tick();
        queue_cmd(rand_cmd(KIND_STOP));
        send_tick();

        // random
        while (pending_cmds.size() < 1750)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                cmd = rand_cmd(KIND_LOAD_SAMPLE);
                if ($urandom_range(0, 1))
                    cmd.address = ADDR_W'($urandom_range(0, 255));
                queue_cmd(cmd);
            end
            else if (pick < 20)
            begin
                cmd = rand_cmd(KIND_LOAD_CLIP);
                case ($urandom_range(0, 19))
                    0: cmd.clip_length = '0;
                    1: ;
                    default: cmd.clip_length = LEN_W'($urandom_range(1, 48));
                endcase
                if ($urandom_range(0, 3) == 0)
                    cmd.clip_start = ADDR_W'($urandom_range(0, 200));
                if ($urandom_range(0, 7) == 0)
                    cmd.clip_start = 19'h7FFFF - ADDR_W'($urandom_range(0, 8));
                queue_cmd(cmd);
            end
            else if (pick < 45)
            begin
                cmd = rand_cmd(KIND_PLAY);
                if ($urandom_range(0, 9) == 0)
                    cmd.volume = '0;
                queue_cmd(cmd);
            end
            else if (pick < 47)
                queue_cmd(rand_cmd(KIND_STOP));
            else if (pick < 49)
                queue_cmd(rand_cmd(3'($urandom_range(5, 7))));
            else
                send_tick();
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            int idle_pct;
            command_t cmd;
            idle_pct = (accepted_cmds < 700) ? 34 : (accepted_cmds < 1400) ? 45 : 0;
            if (in_valid && in_ready)
            begin
                void'(pending_cmds.pop_front());
                accepted_cmds++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    cmd = pending_cmds[0];
                    in_valid <= 1'b1;
                    kind <= cmd.kind;
                    address <= cmd.address;
                    sample <= cmd.sample;
                    clip <= cmd.clip;
                    clip_start <= cmd.clip_start;
                    clip_length <= cmd.clip_length;
                    volume <= cmd.volume;
                    pitch <= cmd.pitch;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !hold_done && taken_frames == 150)
        begin
            hold_done <= 1'b1;
            hold_cycles <= 500;
        end
        else if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            int stall_pct;
            logic signed [SMP_W-1:0] want;
            stall_pct = (accepted_cmds < 700) ? 45 : (accepted_cmds < 1400) ? 34 : 0;
            if (out_valid && out_ready)
            begin
                taken_frames++;
                if (expected_frames.size() == 0)
                begin
                    $error("mixed_sample: no frame expected, actual %0d", mixed_sample);
                    fail_count++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (mixed_sample !== want)
                    begin
                        $error("mixed_sample: expected %0d, actual %0d", want, mixed_sample);
                        fail_count++;
                    end
                end
            end
            out_ready <= (hold_cycles == 0) && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_cmds.size() == 0 && expected_frames.size() == 0);
        repeat (200) @(posedge clk);
        if (expected_frames.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/svm_pkg.sv
hw/rtl/svm_ram.sv
hw/rtl/sample_voice_mixer_core.sv
tb/sv/tb_top.sv
